// ----- src/spco_pkg.sv -----
// Package: shared types and widths for the segment pair capsule overlap block.
`default_nettype none
package spco_pkg;
  localparam int unsigned CoordBits = 20;
  localparam int unsigned LimitBits = 44;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned ProdBits  = 2 * DiffBits;
  localparam int unsigned SumBits   = ProdBits + 1;

  typedef struct packed {
    logic signed [CoordBits-1:0] first_start_x;
    logic signed [CoordBits-1:0] first_start_y;
    logic signed [CoordBits-1:0] first_end_x;
    logic signed [CoordBits-1:0] first_end_y;
    logic signed [CoordBits-1:0] second_start_x;
    logic signed [CoordBits-1:0] second_start_y;
    logic signed [CoordBits-1:0] second_end_x;
    logic signed [CoordBits-1:0] second_end_y;
  } in_word_t;

  typedef struct packed {
    logic overlaps;
    logic crossing;
  } out_word_t;
endpackage
`default_nettype wire

// ----- src/segment_pair_capsule_overlap.sv -----
// Top level: pipelined segment crossing and capsule overlap test.
//
//  channel  | handshake                | payload
//  in       | in_valid_i / in_ready_o  | in_word_i   (spco_pkg::in_word_t)
//  out      | out_valid_o / out_ready_i| out_word_o  (spco_pkg::out_word_t)
//  cfg      | cfg_valid_i / cfg_ready_o| cfg_data_i  (limit_sq)
//
// One word per cycle while the output is not stalled; the distance path has
// six register stages. The whole pipe advances when the output register is
// empty or taken, so a stall holds every stage in place.
// Reset clears valid bits and limit_sq.
`default_nettype none
module segment_pair_capsule_overlap (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  spco_pkg::in_word_t in_word_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output spco_pkg::out_word_t out_word_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [spco_pkg::LimitBits-1:0] cfg_data_i
);
  localparam int unsigned Depth = 6;
  localparam int unsigned DB = spco_pkg::DiffBits;
  localparam int unsigned PB = spco_pkg::ProdBits;
  localparam int unsigned SB = spco_pkg::SumBits;
  localparam int unsigned CB = spco_pkg::CoordBits;

  logic [spco_pkg::LimitBits-1:0] limit_q;
  logic [Depth-1:0] vld_q;
  logic en;
  assign en = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      vld_q   <= '0;
    end else begin
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (en) vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  spco_pkg::in_word_t w;
  assign w = in_word_i;

  // four endpoint-to-segment tests
  logic [3:0] near;
  spco_near u_n0 (.clk_i, .en_i(en), .limit_i(limit_q), .px_i(w.first_start_x),
    .py_i(w.first_start_y), .sx_i(w.second_start_x), .sy_i(w.second_start_y),
    .ex_i(w.second_end_x), .ey_i(w.second_end_y), .near_o(near[0]));
  spco_near u_n1 (.clk_i, .en_i(en), .limit_i(limit_q), .px_i(w.first_end_x),
    .py_i(w.first_end_y), .sx_i(w.second_start_x), .sy_i(w.second_start_y),
    .ex_i(w.second_end_x), .ey_i(w.second_end_y), .near_o(near[1]));
  spco_near u_n2 (.clk_i, .en_i(en), .limit_i(limit_q), .px_i(w.second_start_x),
    .py_i(w.second_start_y), .sx_i(w.first_start_x), .sy_i(w.first_start_y),
    .ex_i(w.first_end_x), .ey_i(w.first_end_y), .near_o(near[2]));
  spco_near u_n3 (.clk_i, .en_i(en), .limit_i(limit_q), .px_i(w.second_end_x),
    .py_i(w.second_end_y), .sx_i(w.first_start_x), .sy_i(w.first_start_y),
    .ex_i(w.first_end_x), .ey_i(w.first_end_y), .near_o(near[3]));

  // crossing path, stage 1: differences and bounding boxes
  logic signed [DB-1:0] abx_q, aby_q, cdx_q, cdy_q;
  logic signed [DB-1:0] acx_q, acy_q, adx_q, ady_q, cax_q, cay_q, cbx_q, cby_q;
  logic [3:0] box1_q;
  function automatic logic in_box(input logic signed [CB-1:0] ax, ay, bx, by, cx, cy);
    logic xo, yo;
    xo = (cx >= ((ax < bx) ? ax : bx)) && (cx <= ((ax < bx) ? bx : ax));
    yo = (cy >= ((ay < by) ? ay : by)) && (cy <= ((ay < by) ? by : ay));
    return xo && yo;
  endfunction
  always_ff @(posedge clk_i) begin
    if (en) begin
      abx_q <= DB'(w.first_end_x) - DB'(w.first_start_x);
      aby_q <= DB'(w.first_end_y) - DB'(w.first_start_y);
      cdx_q <= DB'(w.second_end_x) - DB'(w.second_start_x);
      cdy_q <= DB'(w.second_end_y) - DB'(w.second_start_y);
      acx_q <= DB'(w.second_start_x) - DB'(w.first_start_x);
      acy_q <= DB'(w.second_start_y) - DB'(w.first_start_y);
      adx_q <= DB'(w.second_end_x) - DB'(w.first_start_x);
      ady_q <= DB'(w.second_end_y) - DB'(w.first_start_y);
      cax_q <= DB'(w.first_start_x) - DB'(w.second_start_x);
      cay_q <= DB'(w.first_start_y) - DB'(w.second_start_y);
      cbx_q <= DB'(w.first_end_x) - DB'(w.second_start_x);
      cby_q <= DB'(w.first_end_y) - DB'(w.second_start_y);
      box1_q[0] <= in_box(w.first_start_x, w.first_start_y, w.first_end_x,
                          w.first_end_y, w.second_start_x, w.second_start_y);
      box1_q[1] <= in_box(w.first_start_x, w.first_start_y, w.first_end_x,
                          w.first_end_y, w.second_end_x, w.second_end_y);
      box1_q[2] <= in_box(w.second_start_x, w.second_start_y, w.second_end_x,
                          w.second_end_y, w.first_start_x, w.first_start_y);
      box1_q[3] <= in_box(w.second_start_x, w.second_start_y, w.second_end_x,
                          w.second_end_y, w.first_end_x, w.first_end_y);
    end
  end

  // stage 2: orientation products
  logic signed [PB-1:0] p_q [4];
  logic signed [PB-1:0] q_q [4];
  logic [3:0] box2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= abx_q * acy_q;  q_q[0] <= aby_q * acx_q;
      p_q[1] <= abx_q * ady_q;  q_q[1] <= aby_q * adx_q;
      p_q[2] <= cdx_q * cay_q;  q_q[2] <= cdy_q * cax_q;
      p_q[3] <= cdx_q * cby_q;  q_q[3] <= cdy_q * cbx_q;
      box2_q <= box1_q;
    end
  end

  // stage 3: signs of the four orientations
  logic [3:0] neg_q, zero_q, box3_q;
  logic signed [SB-1:0] o_c [4];
  always_comb begin
    for (int i = 0; i < 4; i++) o_c[i] = SB'(p_q[i]) - SB'(q_q[i]);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        neg_q[i]  <= o_c[i][SB-1];
        zero_q[i] <= o_c[i] == '0;
      end
      box3_q <= box2_q;
    end
  end

  // stage 4: crossing decision, then delay to line up with the distance path
  logic cross4_q, cross5_q, cross6_q;
  logic s12, s34;
  assign s12 = !zero_q[0] && !zero_q[1] && (neg_q[0] != neg_q[1]);
  assign s34 = !zero_q[2] && !zero_q[3] && (neg_q[2] != neg_q[3]);
  always_ff @(posedge clk_i) begin
    if (en) begin
      cross4_q <= (s12 && s34) || |(zero_q & box3_q);
      cross5_q <= cross4_q;
      cross6_q <= cross5_q;
    end
  end

  // output word
  assign out_word_o.crossing = cross6_q;
  assign out_word_o.overlaps = cross6_q || |near;
endmodule
`default_nettype wire

// ----- src/spco_near.sv -----
// Pipelined test: squared distance from a point to a segment below the limit.
`default_nettype none
module spco_near (
  input  logic clk_i,
  input  logic en_i,
  input  logic [spco_pkg::LimitBits-1:0] limit_i,
  input  logic signed [spco_pkg::CoordBits-1:0] px_i,
  input  logic signed [spco_pkg::CoordBits-1:0] py_i,
  input  logic signed [spco_pkg::CoordBits-1:0] sx_i,
  input  logic signed [spco_pkg::CoordBits-1:0] sy_i,
  input  logic signed [spco_pkg::CoordBits-1:0] ex_i,
  input  logic signed [spco_pkg::CoordBits-1:0] ey_i,
  output logic near_o
);
  localparam int unsigned DB = spco_pkg::DiffBits;
  localparam int unsigned PB = spco_pkg::ProdBits;
  localparam int unsigned SB = spco_pkg::SumBits;
  localparam int unsigned LB = spco_pkg::LimitBits;
  localparam int unsigned MB = 2 * SB;
  localparam int unsigned RB = LB + SB;
  // split point for the wide products, and width of one partial product
  localparam int unsigned HB = 22;
  localparam int unsigned PW = 2 * HB;

  // stage 1: differences
  logic signed [DB-1:0] dx_q, dy_q, vx_q, vy_q, wx_q, wy_q;
  logic [LB-1:0] lim1_q, lim2_q, lim3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= DB'(ex_i) - DB'(sx_i);
      dy_q <= DB'(ey_i) - DB'(sy_i);
      vx_q <= DB'(px_i) - DB'(sx_i);
      vy_q <= DB'(py_i) - DB'(sy_i);
      wx_q <= DB'(px_i) - DB'(ex_i);
      wy_q <= DB'(py_i) - DB'(ey_i);
      lim1_q <= limit_i;
    end
  end

  // stage 2: products
  logic signed [PB-1:0] ddx_q, ddy_q, vdx_q, vdy_q, vvx_q, vvy_q, wwx_q, wwy_q;
  logic signed [PB-1:0] cxa_q, cxb_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ddx_q <= dx_q * dx_q;  ddy_q <= dy_q * dy_q;
      vdx_q <= vx_q * dx_q;  vdy_q <= vy_q * dy_q;
      vvx_q <= vx_q * vx_q;  vvy_q <= vy_q * vy_q;
      wwx_q <= wx_q * wx_q;  wwy_q <= wy_q * wy_q;
      cxa_q <= vx_q * dy_q;  cxb_q <= vy_q * dx_q;
      lim2_q <= lim1_q;
    end
  end

  // stage 3: sums, cross product magnitude and region
  logic [SB-1:0] len_q, nv_q, nw_q, mag_q;
  logic pre_q, post_q;
  logic signed [SB-1:0] dot_c, len_c, cr_c;
  assign dot_c = SB'(vdx_q) + SB'(vdy_q);
  assign len_c = SB'(ddx_q) + SB'(ddy_q);
  assign cr_c  = SB'(cxa_q) - SB'(cxb_q);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q  <= len_c;
      nv_q   <= SB'(vvx_q) + SB'(vvy_q);
      nw_q   <= SB'(wwx_q) + SB'(wwy_q);
      mag_q  <= cr_c[SB-1] ? -cr_c : cr_c;
      pre_q  <= dot_c <= 0;
      post_q <= dot_c >= len_c;
      lim3_q <= lim2_q;
    end
  end

  // stage 4: partial products of the interior squares, endpoint compares
  logic [PW-1:0] sll_q, slh_q, shh_q;
  logic [PW-1:0] rll_q, rlh_q, rhl_q, rhh_q;
  logic pre4_q, post4_q, nv4_q, nw4_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sll_q   <= PW'(mag_q[HB-1:0]) * PW'(mag_q[HB-1:0]);
      slh_q   <= PW'(mag_q[SB-1:HB]) * PW'(mag_q[HB-1:0]);
      shh_q   <= PW'(mag_q[SB-1:HB]) * PW'(mag_q[SB-1:HB]);
      rll_q   <= PW'(lim3_q[HB-1:0]) * PW'(len_q[HB-1:0]);
      rlh_q   <= PW'(lim3_q[HB-1:0]) * PW'(len_q[SB-1:HB]);
      rhl_q   <= PW'(lim3_q[LB-1:HB]) * PW'(len_q[HB-1:0]);
      rhh_q   <= PW'(lim3_q[LB-1:HB]) * PW'(len_q[SB-1:HB]);
      nv4_q   <= LB'(nv_q) < lim3_q;
      nw4_q   <= LB'(nw_q) < lim3_q;
      pre4_q  <= pre_q;
      post4_q <= post_q;
    end
  end

  // stage 5: recombine partial products
  logic [MB-1:0] sq_q;
  logic [RB-1:0] rhs_q;
  logic pre5_q, post5_q, nv5_q, nw5_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q    <= (MB'(shh_q) << PW) + (MB'(slh_q) << (HB + 1)) + MB'(sll_q);
      rhs_q   <= (RB'(rhh_q) << PW) + ((RB'(rlh_q) + RB'(rhl_q)) << HB) + RB'(rll_q);
      pre5_q  <= pre4_q;
      post5_q <= post4_q;
      nv5_q   <= nv4_q;
      nw5_q   <= nw4_q;
    end
  end

  // stage 6: decision
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (pre5_q) near_o <= nv5_q;
      else if (post5_q) near_o <= nw5_q;
      else near_o <= RB'(sq_q) < rhs_q;
    end
  end
endmodule
`default_nettype wire
